/* src/gpp_pkg.sv */
// ============================================================================
// gpp_pkg
// Shared types and constants of the price path step generator.
// ============================================================================
package gpp_pkg;

    localparam int PRICE_W    = 40;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 16;
    localparam int VOL_W      = 18;
    localparam int RATE_W     = 20;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] Q30_ONE   = 31'd1073741824;
    localparam logic signed [37:0] EXP_LIM = 38'sd4194304;

    localparam logic [CFG_IDX_W-1:0] REG_START_PRICE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLATILITY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_RATE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RISK_FREE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL     = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_DIV, ST_T1, ST_SQRT, ST_T2, ST_EMIT0,
        ST_X, ST_Y, ST_G, ST_TG, ST_REC, ST_COR, ST_MH, ST_ML, ST_SC, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_START, OP_DIV, OP_T1, OP_SQRT, OP_T2, OP_EMIT0,
        OP_X, OP_Y, OP_G, OP_TG, OP_REC, OP_COR, OP_MH, OP_ML, OP_SC, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] iter;
    } t_cmd;

    typedef struct packed {
        logic idx_zero;
        logic out_free;
    } t_sts;

    // floor(2^31 / k) for the series divisor k.
    function automatic logic [31:0] recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'd2147483648;
            4'd2:    r = 32'd1073741824;
            4'd3:    r = 32'd715827882;
            4'd4:    r = 32'd536870912;
            4'd5:    r = 32'd429496729;
            4'd6:    r = 32'd357913941;
            4'd7:    r = 32'd306783378;
            4'd8:    r = 32'd268435456;
            4'd9:    r = 32'd238609294;
            4'd10:   r = 32'd214748364;
            4'd11:   r = 32'd195225786;
            4'd12:   r = 32'd178956970;
            4'd13:   r = 32'd165191049;
            4'd14:   r = 32'd153391689;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/gpp_in_if.sv */
// ============================================================================
// gpp_in_if
// Sample channel: one standard normal draw per transaction.
// ============================================================================
interface gpp_in_if import gpp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] normal_sample;

    modport source (output valid, output normal_sample, input ready);
    modport sink (input valid, input normal_sample, output ready);
endinterface

/* src/gpp_out_if.sv */
// ============================================================================
// gpp_out_if
// Result channel: one path price per transaction.
// ============================================================================
interface gpp_out_if import gpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;
    logic [STEP_W-1:0]  step_number;
    logic               last;
    logic               saturated;

    modport source (output valid, output price, output step_number, output last,
                    output saturated, input ready);
    modport sink (input valid, input price, input step_number, input last,
                  input saturated, output ready);
endinterface

/* src/gpp_ctrl.sv */
// ============================================================================
// gpp_ctrl
// Sequencer that steps the datapath through path setup and one price step.
// ============================================================================
module gpp_ctrl import gpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.idx_zero ? ST_START : ST_X;
                end
            end
            ST_START: begin
                n_state = ST_DIV;
                n_cnt   = 6'd0;
            end
            ST_DIV: begin
                if (r_cnt == 6'd31) begin
                    n_state = ST_T1;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_T1: begin
                n_state = ST_SQRT;
                n_cnt   = 6'd0;
            end
            ST_SQRT: begin
                if (r_cnt == 6'd23) begin
                    n_state = ST_T2;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_T2:    n_state = ST_EMIT0;
            ST_EMIT0: begin
                if (i_sts.out_free) begin
                    n_state = ST_X;
                end
            end
            ST_X:     n_state = ST_Y;
            ST_Y:     n_state = ST_G;
            ST_G: begin
                n_state = ST_TG;
                n_cnt   = 6'd1;
            end
            ST_TG:    n_state = ST_REC;
            ST_REC:   n_state = ST_COR;
            ST_COR: begin
                if (r_cnt == 6'd14) begin
                    n_state = ST_MH;
                end else begin
                    n_state = ST_TG;
                    n_cnt   = r_cnt + 6'd1;
                end
            end
            ST_MH:    n_state = ST_ML;
            ST_ML:    n_state = ST_SC;
            ST_SC:    n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NOP;
        o_cmd.iter = r_cnt[3:0];
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            ST_START: o_cmd.op = OP_START;
            ST_DIV:   o_cmd.op = OP_DIV;
            ST_T1:    o_cmd.op = OP_T1;
            ST_SQRT:  o_cmd.op = OP_SQRT;
            ST_T2:    o_cmd.op = OP_T2;
            ST_EMIT0: o_cmd.op = i_sts.out_free ? OP_EMIT0 : OP_NOP;
            ST_X:     o_cmd.op = OP_X;
            ST_Y:     o_cmd.op = OP_Y;
            ST_G:     o_cmd.op = OP_G;
            ST_TG:    o_cmd.op = OP_TG;
            ST_REC:   o_cmd.op = OP_REC;
            ST_COR:   o_cmd.op = OP_COR;
            ST_MH:    o_cmd.op = OP_MH;
            ST_ML:    o_cmd.op = OP_ML;
            ST_SC:    o_cmd.op = OP_SC;
            ST_EMIT:  o_cmd.op = i_sts.out_free ? OP_EMIT : OP_NOP;
            default:  o_cmd.op = OP_NOP;
        endcase
    end

endmodule

/* src/gpp_dp.sv */
// ============================================================================
// gpp_dp
// Configuration registers, path state, arithmetic units and result register.
// ============================================================================
module gpp_dp import gpp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_ready,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    output logic [PRICE_W-1:0]         o_price,
    output logic [STEP_W-1:0]          o_step_number,
    output logic                       o_last,
    output logic                       o_saturated
);

    logic [PRICE_W-1:0] r_start_price;
    logic [TIME_W-1:0]  r_start_time, r_end_time;
    logic [STEP_W-1:0]  r_step_count;
    logic [VOL_W-1:0]   r_vol;
    logic [RATE_W-1:0]  r_drift_rate, r_risk_free;
    logic               r_neutral;

    logic signed [SAMPLE_W-1:0] r_eps;
    logic [STEP_W-1:0]  r_idx, r_sn;
    logic [PRICE_W-1:0] r_price;
    logic [31:0]        r_drift, r_diff;
    logic [20:0]        r_a;
    logic [15:0]        r_dvs, r_rem;
    logic [31:0]        r_num;
    logic [47:0]        r_sv;
    logic [25:0]        r_srem;
    logic [23:0]        r_root;
    logic [23:0]        r_x;
    logic [7:0]         r_n;
    logic [29:0]        r_f, r_g, r_v, r_q0;
    logic [30:0]        r_term, r_sum;
    logic [70:0]        r_w;
    logic               r_sat, r_last;
    logic               r_ov;
    logic [PRICE_W-1:0] r_o_price;
    logic [STEP_W-1:0]  r_o_step;
    logic               r_o_last, r_o_sat;

    logic [15:0]        steps_eff;
    logic [35:0]        vv;
    logic [19:0]        rate_sel;
    logic [20:0]        a_next;
    logic [16:0]        div_rem2;
    logic               div_ge;
    logic [20:0]        t1_mag;
    logic [52:0]        t1_prod;
    logic [36:0]        t1_s;
    logic [31:0]        t1_val;
    logic [27:0]        sq_rem2, sq_trial;
    logic               sq_ge;
    logic [41:0]        t2_prod;
    logic [15:0]        x_mag;
    logic [47:0]        x_prod;
    logic [37:0]        x_sx, x_sum;
    logic [23:0]        x_val;
    logic [22:0]        y_mag;
    logic [53:0]        y_prod;
    logic [38:0]        y_y, y_o;
    logic [59:0]        g_prod;
    logic [60:0]        tg_prod;
    logic [61:0]        rec_prod;
    logic [33:0]        cor_prod;
    logic [29:0]        cor_r, cor_q;
    logic [50:0]        mh_prod, ml_prod;
    logic [8:0]         sc_nm;
    logic [7:0]         sc_sh;
    logic [70:0]        sc_rs, sc_ls;
    logic               sc_sat;
    logic [PRICE_W-1:0] sc_price;
    logic [STEP_W-1:0]  idx1;
    logic               sc_last;
    logic               out_free;

    assign out_free       = !r_ov || i_out_ready;
    assign o_sts.out_free = out_free;
    assign o_sts.idx_zero = (r_idx == '0);

    always_comb begin
        steps_eff = (r_step_count == '0) ? 16'd1 : r_step_count;
        vv        = 36'(r_vol) * 36'(r_vol);
        rate_sel  = r_neutral ? r_risk_free : r_drift_rate;
        a_next    = {rate_sel[19], rate_sel} - {2'b00, vv[35:17]};

        div_rem2 = {r_rem, r_num[31]};
        div_ge   = (div_rem2 >= {1'b0, r_dvs});

        t1_mag  = r_a[20] ? (21'd0 - r_a) : r_a;
        t1_prod = 53'(t1_mag) * 53'(r_num);
        t1_s    = t1_prod[52:16];
        if (!r_a[20]) begin
            t1_val = (t1_s > 37'h07FFFFFFF) ? 32'h7FFFFFFF : t1_s[31:0];
        end else begin
            t1_val = (t1_s > 37'h080000000) ? 32'h80000000 : (32'd0 - t1_s[31:0]);
        end

        sq_rem2  = {r_srem, r_sv[47:46]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_rem2 >= sq_trial);

        t2_prod = 42'(r_vol) * 42'(r_root);

        x_mag  = r_eps[15] ? (16'd0 - r_eps) : r_eps;
        x_prod = 48'(x_mag) * 48'(r_diff);
        x_sx   = r_eps[15] ? (38'd0 - {2'b00, x_prod[47:12]}) : {2'b00, x_prod[47:12]};
        x_sum  = {{6{r_drift[31]}}, r_drift} + x_sx;
        if ($signed(x_sum) > EXP_LIM) begin
            x_val = 24'(EXP_LIM);
        end else if ($signed(x_sum) < -EXP_LIM) begin
            x_val = 24'(-EXP_LIM);
        end else begin
            x_val = x_sum[23:0];
        end

        y_mag  = r_x[23] ? 23'(24'd0 - r_x) : r_x[22:0];
        y_prod = 54'(y_mag) * 54'(LOG2E_Q30);
        y_y    = r_x[23] ? (39'd0 - {1'b0, y_prod[53:16]}) : {1'b0, y_prod[53:16]};
        y_o    = y_y + (39'd1 << 37);

        g_prod   = 60'(r_f) * 60'(LN2_Q30);
        tg_prod  = 61'(r_term) * 61'(r_g);
        rec_prod = 62'(r_v) * 62'(recip(i_cmd.iter));
        cor_prod = 34'(r_q0) * 34'(i_cmd.iter);
        cor_r    = r_v - cor_prod[29:0];
        cor_q    = (cor_r >= 30'(i_cmd.iter)) ? (r_q0 + 30'd1) : r_q0;

        mh_prod = 51'(r_price[39:20]) * 51'(r_sum);
        ml_prod = 51'(r_price[19:0]) * 51'(r_sum);

        sc_nm = {r_n[7], r_n} - 9'd30;
        sc_sh = 8'(9'd0 - sc_nm);
        sc_rs = r_w >> sc_sh;
        sc_ls = r_w << sc_nm[6:0];
        if (sc_nm[8]) begin
            sc_sat = |sc_rs[70:40];
            sc_price = sc_rs[39:0];
        end else begin
            if (sc_nm[6:0] > 7'd40) begin
                sc_sat = |r_w;
            end else begin
                sc_sat = |(r_w >> (6'd40 - sc_nm[5:0]));
            end
            sc_price = sc_ls[39:0];
        end
        if (sc_sat) begin
            sc_price = PRICE_MAX;
        end
        idx1    = r_idx + 16'd1;
        sc_last = (idx1 >= steps_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_price <= 40'd6553600;
            r_start_time  <= '0;
            r_end_time    <= 32'd65536;
            r_step_count  <= 16'd252;
            r_vol         <= 18'd13107;
            r_drift_rate  <= 20'd3277;
            r_risk_free   <= 20'd3277;
            r_neutral     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_PRICE: r_start_price <= i_cfg_data[39:0];
                REG_START_TIME:  r_start_time  <= i_cfg_data[31:0];
                REG_END_TIME:    r_end_time    <= i_cfg_data[31:0];
                REG_STEP_COUNT:  r_step_count  <= i_cfg_data[15:0];
                REG_VOLATILITY:  r_vol         <= i_cfg_data[17:0];
                REG_DRIFT_RATE:  r_drift_rate  <= i_cfg_data[19:0];
                REG_RISK_FREE:   r_risk_free   <= i_cfg_data[19:0];
                REG_NEUTRAL:     r_neutral     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_price <= '0;
            r_drift <= '0;
            r_diff  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_out_ready && (i_cmd.op != OP_EMIT0) && (i_cmd.op != OP_EMIT)) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: r_eps <= i_sample;
                OP_START: begin
                    r_price <= r_start_price;
                    r_a     <= a_next;
                    r_dvs   <= steps_eff;
                    r_num   <= (r_end_time > r_start_time) ? (r_end_time - r_start_time) : '0;
                    r_rem   <= '0;
                end
                OP_DIV: begin
                    r_rem <= div_ge ? 16'(div_rem2 - {1'b0, r_dvs}) : div_rem2[15:0];
                    r_num <= {r_num[30:0], div_ge};
                end
                OP_T1: begin
                    r_drift <= t1_val;
                    r_sv    <= {r_num, 16'd0};
                    r_srem  <= '0;
                    r_root  <= '0;
                end
                OP_SQRT: begin
                    r_srem <= sq_ge ? 26'(sq_rem2 - sq_trial) : sq_rem2[25:0];
                    r_root <= {r_root[22:0], sq_ge};
                    r_sv   <= {r_sv[45:0], 2'b00};
                end
                OP_T2: r_diff <= {6'd0, t2_prod[41:16]};
                OP_EMIT0: begin
                    r_ov      <= 1'b1;
                    r_o_price <= r_price;
                    r_o_step  <= '0;
                    r_o_last  <= 1'b0;
                    r_o_sat   <= 1'b0;
                end
                OP_X: r_x <= x_val;
                OP_Y: begin
                    r_n <= {~y_o[37], y_o[36:30]};
                    r_f <= y_o[29:0];
                end
                OP_G: begin
                    r_g    <= g_prod[59:30];
                    r_term <= Q30_ONE;
                    r_sum  <= Q30_ONE;
                end
                OP_TG:  r_v  <= tg_prod[59:30];
                OP_REC: r_q0 <= rec_prod[60:31];
                OP_COR: begin
                    r_term <= {1'b0, cor_q};
                    r_sum  <= r_sum + {1'b0, cor_q};
                end
                OP_MH: r_w <= 71'(mh_prod);
                OP_ML: r_w <= {r_w[50:0], 20'd0} + 71'(ml_prod);
                OP_SC: begin
                    r_price <= sc_price;
                    r_sat   <= sc_sat;
                    r_sn    <= idx1;
                    r_last  <= sc_last;
                    r_idx   <= sc_last ? '0 : idx1;
                end
                OP_EMIT: begin
                    r_ov      <= 1'b1;
                    r_o_price <= r_price;
                    r_o_step  <= r_sn;
                    r_o_last  <= r_last;
                    r_o_sat   <= r_sat;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_price       = r_o_price;
    assign o_step_number = r_o_step;
    assign o_last        = r_o_last;
    assign o_saturated   = r_o_sat;

endmodule

/* src/gbm_price_path_step.sv */
// ============================================================================
// gbm_price_path_step
// Exact-step geometric Brownian motion price path generator.
// ============================================================================
// Each transaction on i_smp carries one standard normal sample in Q4.12, and
// each transaction on o_res carries one price in unsigned Q24.16 with its
// index in the path, a last flag and a saturation flag. Registers are
// written through i_cfg_we, i_cfg_index and i_cfg_data. The user writes them
// only while the block idles; the block itself does not enforce it. The first
// sample of a path gives two results: the start price and the first step.
// Path setup runs a divider for the time step and then a square root before
// the start price appears. Each step then runs the 14-term exponential series,
// each term through the TG, REC and COR states of the multiply-correct path.
// One sample is worked on at a time; a new sample is taken as soon as the
// previous result sits in the output register, even while it waits.
// When the receiver stalls, the block holds before loading the next result.
// Reset returns the registers to their defaults and starts a new path.
// ============================================================================
module gbm_price_path_step import gpp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpp_in_if.sink                i_smp,
    gpp_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_smp.ready = w_in_ready;

    gpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    gpp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_smp.normal_sample),
        .i_out_ready   (o_res.ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_res.valid),
        .o_price       (o_res.price),
        .o_step_number (o_res.step_number),
        .o_last        (o_res.last),
        .o_saturated   (o_res.saturated)
    );

endmodule

/* bench/gbm_price_path_step_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// gbm_price_path_step_tb
// Self-checking bench for the exact-step price path generator.
// ============================================================================
// Samples are sent from a queue by a clocked driver. A bit-exact predictor
// of the path arithmetic computes the expected prices for each accepted
// sample. A clocked monitor compares every result transaction with the
// oldest expected price. Both sides idle at random. Registers are rewritten
// between phases while the block is idle, with and without open paths.
// ============================================================================
module gbm_price_path_step_tb import gpp_pkg::*; ();

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [PRICE_W-1:0] price;
        logic [STEP_W-1:0]  step_number;
        logic               last;
        logic               saturated;
    } t_price_rec;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gpp_in_if  smp ();
    gpp_out_if res ();

    gbm_price_path_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp.sink),
        .o_res       (res.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register copies and path state of the predictor.
    longint unsigned reg_start_price, reg_start_time, reg_end_time, reg_steps;
    longint unsigned reg_vol, reg_drift, reg_rfree, reg_neutral;
    longint unsigned path_price, path_index, diffusion_q16;
    longint          drift_q16;

    logic [SAMPLE_W-1:0] sample_q[$];
    t_price_rec          expected_prices[$];
    int  errors;
    int  cycles;
    bit  hold_samples;
    bit  no_idle;
    int  send_gap;
    int  recv_stall;

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint sext(longint unsigned v, int w);
        longint unsigned m;
        m = 64'd1 << (w - 1);
        v = v & ((m << 1) - 1);
        return longint'(v ^ m) - longint'(m);
    endfunction

    function automatic longint scaled_product(longint a, longint unsigned b, int s);
        longint unsigned mag, p;
        mag = (a < 0) ? (64'd0 - longint'(a)) : a;
        p = (mag * b) >> s;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned pow2_fraction(longint unsigned f);
        longint unsigned g, term, sum;
        g = (f * 64'd744261118) >> 30;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * g) >> 30) / k;
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic longint unsigned grow_price(longint unsigned p, longint x,
                                                   output bit sat);
        longint lim, y;
        longint unsigned yo, e, hi, lo, q, r, whi, wlo, pmax;
        int n, sh;
        pmax = 64'hFF_FFFF_FFFF;
        lim = longint'(64) << 16;
        sat = 0;
        if (x > lim) x = lim;
        if (x < -lim) x = -lim;
        y = scaled_product(x, 64'd1549082005, 16);
        yo = y + (longint'(128) << 30);
        n = int'(yo >> 30) - 128;
        e = pow2_fraction(yo & ((64'd1 << 30) - 1));
        hi = (p >> 20) * e;
        lo = (p & 64'hFFFFF) * e;
        q = hi + (lo >> 20);
        r = lo & 64'hFFFFF;
        whi = q >> 44;
        wlo = (q << 20) | r;
        sh = 30 - n;
        if (sh > 0) begin
            if (sh >= 64) begin
                wlo = whi >> (sh - 64);
                whi = 0;
            end else begin
                wlo = (wlo >> sh) | (whi << (64 - sh));
                whi = whi >> sh;
            end
            if (whi != 0 || wlo > pmax) begin
                sat = 1;
                return pmax;
            end
            return wlo;
        end
        if (whi != 0 || wlo > (pmax >> (-sh))) begin
            sat = 1;
            return pmax;
        end
        return wlo << (-sh);
    endfunction

    task automatic predict_prices(input logic [SAMPLE_W-1:0] sample);
        longint          eps, x, rate, t1;
        longint unsigned steps, dt, half, t2;
        bit              sat, last;
        t_price_rec      rec;
        eps = sext(sample, 16);
        steps = reg_steps & 64'hFFFF;
        if (steps == 0) steps = 1;
        if (path_index == 0) begin
            dt = (reg_end_time > reg_start_time) ?
                 (reg_end_time - reg_start_time) / steps : 0;
            half = (reg_vol * reg_vol) >> 17;
            rate = sext(reg_neutral ? reg_rfree : reg_drift, 20);
            t1 = scaled_product(rate - longint'(half), dt, 16);
            t2 = (reg_vol * int_sqrt(dt << 16)) >> 16;
            if (t1 > 64'sd2147483647) t1 = 64'sd2147483647;
            if (t1 < -64'sd2147483648) t1 = -64'sd2147483648;
            if (t2 > 64'hFFFFFFFF) t2 = 64'hFFFFFFFF;
            drift_q16 = t1;
            diffusion_q16 = t2;
            path_price = reg_start_price;
            rec.price = path_price[PRICE_W-1:0];
            rec.step_number = '0;
            rec.last = 0;
            rec.saturated = 0;
            expected_prices.push_back(rec);
        end
        x = drift_q16 + scaled_product(eps, diffusion_q16, 12);
        path_price = grow_price(path_price, x, sat);
        path_index = (path_index + 1) & 64'hFFFF;
        last = (path_index >= steps);
        rec.price = path_price[PRICE_W-1:0];
        rec.step_number = path_index[STEP_W-1:0];
        rec.last = last;
        rec.saturated = sat;
        expected_prices.push_back(rec);
        if (last) path_index = 0;
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        smp.valid = 0;
        smp.normal_sample = '0;
        res.ready = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 0;
            smp.normal_sample <= '0;
            send_gap <= 0;
        end else begin
            if (smp.valid && smp.ready) predict_prices(smp.normal_sample);
            if (smp.valid && !smp.ready) begin
                smp.valid <= 1;
            end else if (!hold_samples && sample_q.size() > 0 && send_gap == 0) begin
                smp.valid <= 1;
                smp.normal_sample <= sample_q.pop_front();
                send_gap <= pick_gap();
            end else begin
                smp.valid <= 0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_price_rec e;
        if (!i_rst_n) begin
            res.ready <= 0;
            recv_stall <= 0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_prices.size() == 0) begin
                    report_mismatch("result transaction with no expected price");
                end else begin
                    e = expected_prices.pop_front();
                    if (res.price !== e.price)
                        report_mismatch($sformatf("price %0d, expected %0d",
                                                  res.price, e.price));
                    if (res.step_number !== e.step_number)
                        report_mismatch($sformatf("step_number %0d, expected %0d",
                                                  res.step_number, e.step_number));
                    if (res.last !== e.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  res.last, e.last));
                    if (res.saturated !== e.saturated)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  res.saturated, e.saturated));
                end
            end
            if (recv_stall > 0) begin
                res.ready <= 0;
                recv_stall <= recv_stall - 1;
            end else begin
                res.ready <= 1;
                recv_stall <= pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v[CFG_DATA_W-1:0];
        case (idx)
            REG_START_PRICE: reg_start_price = v & 64'hFF_FFFF_FFFF;
            REG_START_TIME:  reg_start_time = v & 64'hFFFFFFFF;
            REG_END_TIME:    reg_end_time = v & 64'hFFFFFFFF;
            REG_STEP_COUNT:  reg_steps = v & 64'hFFFF;
            REG_VOLATILITY:  reg_vol = v & 64'h3FFFF;
            REG_DRIFT_RATE:  reg_drift = v & 64'hFFFFF;
            REG_RISK_FREE:   reg_rfree = v & 64'hFFFFF;
            REG_NEUTRAL:     reg_neutral = v & 64'h1;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic write_all(input longint unsigned p, t0, t1, n, vol, dr, rf, nm);
        write_reg(REG_START_PRICE, p);
        write_reg(REG_START_TIME, t0);
        write_reg(REG_END_TIME, t1);
        write_reg(REG_STEP_COUNT, n);
        write_reg(REG_VOLATILITY, vol);
        write_reg(REG_DRIFT_RATE, dr);
        write_reg(REG_RISK_FREE, rf);
        write_reg(REG_NEUTRAL, nm);
    endtask

    // Lets the queued samples go and waits until every expected price came.
    task automatic run_and_drain();
        hold_samples = 0;
        @(negedge i_clk);
        while (sample_q.size() != 0 || smp.valid || expected_prices.size() != 0)
            @(negedge i_clk);
        hold_samples = 1;
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(0, 16384) - 8192);
    endfunction

    function automatic longint unsigned random_rate();
        case ($urandom_range(0, 5))
            0: return 64'h80000;
            1: return 64'h7FFFF;
            2: return 64'($urandom & 32'hFFFFF);
            default: return 64'(20'($urandom_range(0, 16384) - 4096));
        endcase
    endfunction

    initial begin
        longint unsigned p, t0, t1, n, vol;
        errors = 0;
        cycles = 0;
        hold_samples = 1;
        no_idle = 0;
        reg_start_price = 6553600;
        reg_start_time = 0;
        reg_end_time = 65536;
        reg_steps = 252;
        reg_vol = 13107;
        reg_drift = 3277;
        reg_rfree = 3277;
        reg_neutral = 0;
        path_price = 0;
        path_index = 0;
        drift_q16 = 0;
        diffusion_q16 = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (5) @(posedge i_clk);

        // Default registers, sample extremes.
        sample_q = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA};
        run_and_drain();
        // Open path left from the defaults, then a short path that saturates.
        write_all(64'hFF_FFFF_FFFF, 0, 64'hFFFFFFFF, 3, 64'h3FFFF, 64'h7FFFF, 0, 0);
        sample_q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000};
        run_and_drain();
        // Zero price, zero step count, end before start, neutral rate at minimum.
        write_all(0, 64'hFFFFFFFF, 0, 0, 0, 64'h80000, 64'h80000, 1);
        sample_q = '{16'h8000, 16'h7FFF, 16'h1234};
        run_and_drain();
        // Long horizon with maximal downward drift so the price falls to zero.
        write_all(64'd6553600, 0, 64'hFFFF0000, 2, 64'h3FFFF, 64'h80000, 64'h7FFFF, 0);
        sample_q = '{16'h8000, 16'h8000, 16'h0000, 16'h7FFF};
        run_and_drain();

        for (int ph = 0; ph < 12; ph++) begin
            no_idle = (ph % 4 == 3);
            case ($urandom_range(0, 5))
                0: p = 64'hFF_FFFF_FFFF;
                1: p = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
                2: p = 64'($urandom_range(0, 3));
                default: p = 64'($urandom_range(1, 500)) << 16;
            endcase
            t0 = ($urandom_range(0, 3) == 0) ? 64'($urandom)
                                              : 64'($urandom_range(0, 65536));
            t1 = ($urandom_range(0, 3) == 0) ? 64'($urandom)
                                              : t0 + 64'($urandom_range(0, 262144));
            case ($urandom_range(0, 7))
                0: n = 64'hFFFF;
                1: n = 0;
                2: n = 64'($urandom_range(100, 300));
                default: n = 64'($urandom_range(1, 12));
            endcase
            vol = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 262143))
                                               : 64'($urandom_range(0, 40000));
            write_all(p, t0, t1, n, vol, random_rate(), random_rate(),
                      64'($urandom_range(0, 1)));
            for (int i = 0; i < 85; i++) sample_q.push_back(random_sample());
            run_and_drain();
            // A mid-phase step count change lands inside an open path.
            if (ph % 3 == 1) begin
                write_reg(REG_STEP_COUNT, 64'($urandom_range(1, 6)));
                for (int i = 0; i < 10; i++) sample_q.push_back(random_sample());
                run_and_drain();
            end
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/gpp_pkg.sv
src/gpp_in_if.sv
src/gpp_out_if.sv
src/gpp_ctrl.sv
src/gpp_dp.sv
src/gbm_price_path_step.sv
bench/gbm_price_path_step_tb.sv
